@@ hdl/silsu_pkg.sv @@
// ----------------------------------------------------------------------------
// Scaled-index load/store unit package
// Shared constants, payload structs, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package silsu_pkg;

	localparam int MEM_BYTES_DEF = 4096;
	localparam int NUM_REGS_DEF  = 16;

	localparam logic [31:0] ACC_RESET = 32'hFF01_FF01;

	localparam int          WIN_W          = 12;
	localparam logic [11:0] WIN_LOW_RESET  = 12'd1024;
	localparam logic [11:0] WIN_HIGH_RESET = 12'd4092;

	localparam int          CFG_IDX_W    = 2;
	localparam logic [1:0]  CFG_WIN_LOW  = 2'd0;
	localparam logic [1:0]  CFG_WIN_HIGH = 2'd1;

	localparam logic [1:0]  FUNC_LEA   = 2'd0;
	localparam logic [1:0]  FUNC_STORE = 2'd1;
	localparam logic [1:0]  FUNC_LOAD  = 2'd2;

	localparam logic [1:0]  LAST_BYTE = 2'd3;

	typedef struct packed {
		logic [1:0]         func;
		logic [3:0]         dest_reg;
		logic signed [31:0] displacement;
		logic [3:0]         base_reg;
		logic [3:0]         index_reg;
		logic [7:0]         scale;
	} op_t;

	typedef struct packed {
		logic signed [31:0] effective_address;
		logic [31:0]        accumulator_value;
		logic               address_fault;
	} result_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_ADD,
		S_CHK,
		S_STORE,
		S_LOAD,
		S_WAIT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       capture;
		logic       mul;
		logic       add;
		logic       chk;
		logic       reg_wr;
		logic       mem_wr;
		logic       mem_rd;
		logic       clr_step;
		logic [1:0] byte_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       fault;
		logic       clr_last;
	} dp_stat_t;

endpackage

@@ hdl/scaled_index_load_store_unit.sv @@
// ----------------------------------------------------------------------------
// Scaled-index load/store unit
// Computes displacement + base + index * scale and uses it to load an
// effective address into a register, or to store or load the accumulator.
// ----------------------------------------------------------------------------
// Usage. An operation is taken on a rising edge where start is high and busy
// is low; op carries its fields. Its result appears on result for exactly
// one cycle with done high. The receiver cannot stall, so nothing is held
// back waiting for it: one beat per operation, always delivered.
// Load effective address, unused codes and any faulted access give done
// after the register, multiply, add and check stages. A store or a load
// then passes its word through the single-port byte memory, which moves one
// byte a cycle, and a load waits in one more state for its last byte. The
// next operation is taken only once the block is back in idle after done.
// After reset the controller sweeps all MEM_BYTES bytes (4096 by default) of
// the byte memory to zero, one byte a cycle, holding busy high until it ends.
// The register file reads as zero and the accumulator as 0xFF01FF01 until
// written. The window registers are written through cfg_valid and cfg_ready
// at any time, including during the sweep; cfg_ready is always high, and
// indexes other than the two window registers are ignored.
// ----------------------------------------------------------------------------
module scaled_index_load_store_unit #(
	parameter int MEM_BYTES = silsu_pkg::MEM_BYTES_DEF,
	parameter int NUM_REGS  = silsu_pkg::NUM_REGS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  silsu_pkg::op_t                  op,
	output logic                            busy,
	output logic                            done,
	output silsu_pkg::result_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [silsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [silsu_pkg::WIN_W-1:0]     cfg_data
);

	silsu_pkg::dp_cmd_t  cmd;
	silsu_pkg::dp_stat_t stat;
	logic                cfg_we;

	// Configuration beats are always accepted; cfg_ready is tied high.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	silsu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	silsu_dp #(
		.MEM_BYTES (MEM_BYTES),
		.NUM_REGS  (NUM_REGS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

@@ hdl/silsu_dp.sv @@
// ----------------------------------------------------------------------------
// Scaled-index load/store unit datapath
// Register file, address arithmetic, window check, accumulator and the
// byte memory, all sequenced by commands from the controller.
// ----------------------------------------------------------------------------
module silsu_dp #(
	parameter int MEM_BYTES = silsu_pkg::MEM_BYTES_DEF,
	parameter int NUM_REGS  = silsu_pkg::NUM_REGS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  silsu_pkg::op_t                  op,
	input  silsu_pkg::dp_cmd_t              cmd,
	output silsu_pkg::dp_stat_t             stat,
	output silsu_pkg::result_t              result,
	input  logic                            cfg_we,
	input  logic [silsu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [silsu_pkg::WIN_W-1:0]     cfg_data
);

	localparam int          AW         = $clog2(MEM_BYTES);
	localparam int          RW         = $clog2(NUM_REGS);
	localparam logic [31:0] LAST_START = 32'(MEM_BYTES - 4);
	localparam logic [31:0] REG_COUNT  = 32'(NUM_REGS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);

	logic [31:0]   rf_q [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [7:0]    mem_q [MEM_BYTES];

	silsu_pkg::op_t op_q;
	logic [31:0]   base_rd_q;
	logic [31:0]   idx_rd_q;
	logic          base_ok_q;
	logic          idx_ok_q;
	logic [31:0]   prod_q;
	logic [31:0]   sum_q;
	logic [31:0]   ea_q;
	logic          fault_q;
	logic [31:0]   acc_q;
	logic [7:0]    rdata_q;
	logic          pend_q;
	logic [AW-1:0] clr_addr_q;
	logic [silsu_pkg::WIN_W-1:0] win_lo_q;
	logic [silsu_pkg::WIN_W-1:0] win_hi_q;

	logic [RW-1:0] base_idx;
	logic [RW-1:0] idx_idx;
	logic [RW-1:0] dest_idx;
	logic          base_in;
	logic          idx_in;
	logic          dest_in;
	logic [31:0]   base_val;
	logic [31:0]   idx_val;
	logic          fault_c;
	logic          is_mem;
	logic [AW-1:0] mem_addr;
	logic          mem_we;
	logic [7:0]    mem_wd;

	assign base_idx = RW'(op.base_reg);
	assign idx_idx  = RW'(op.index_reg);
	assign dest_idx = RW'(op_q.dest_reg);
	assign base_in  = 32'(op.base_reg) < REG_COUNT;
	assign idx_in   = 32'(op.index_reg) < REG_COUNT;
	assign dest_in  = 32'(op_q.dest_reg) < REG_COUNT;

	// Registers never written, or out of range, read as zero.
	assign base_val = base_ok_q ? base_rd_q : '0;
	assign idx_val  = idx_ok_q ? idx_rd_q : '0;

	// A negative address, one outside the window, or a word running past
	// the end of memory faults.
	assign fault_c = ea_q[31] || (ea_q <= 32'(win_lo_q)) || (ea_q > 32'(win_hi_q)) ||
		(ea_q > LAST_START);
	assign is_mem = (op_q.func == silsu_pkg::FUNC_STORE) || (op_q.func == silsu_pkg::FUNC_LOAD);

	assign mem_addr = cmd.clr_step ? clr_addr_q : ea_q[AW-1:0] + AW'(cmd.byte_sel);
	assign mem_we   = cmd.clr_step || cmd.mem_wr;
	assign mem_wd   = cmd.clr_step ? 8'h00 : acc_q[{~cmd.byte_sel, 3'b000} +: 8];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= op;
			base_rd_q <= rf_q[base_idx];
			idx_rd_q  <= rf_q[idx_idx];
			base_ok_q <= base_in && rf_vld_q[base_idx];
			idx_ok_q  <= idx_in && rf_vld_q[idx_idx];
		end
		if (cmd.mul) begin
			prod_q <= idx_val * 32'(op_q.scale);
			sum_q  <= $unsigned(op_q.displacement) + base_val;
		end
		if (cmd.add) begin
			ea_q <= sum_q + prod_q;
		end
		if (cmd.chk) begin
			fault_q <= is_mem && fault_c;
		end
		if (cmd.reg_wr && dest_in) begin
			rf_q[dest_idx] <= ea_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_addr] <= mem_wd;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem_q[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q   <= '0;
			acc_q      <= silsu_pkg::ACC_RESET;
			pend_q     <= 1'b0;
			clr_addr_q <= '0;
			win_lo_q   <= silsu_pkg::WIN_LOW_RESET;
			win_hi_q   <= silsu_pkg::WIN_HIGH_RESET;
		end else begin
			if (cmd.reg_wr && dest_in) begin
				rf_vld_q[dest_idx] <= 1'b1;
			end
			// Bytes come back most significant first and shift in from the right.
			pend_q <= cmd.mem_rd;
			if (pend_q) begin
				acc_q <= {acc_q[23:0], rdata_q};
			end
			if (cmd.clr_step) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					silsu_pkg::CFG_WIN_LOW:  win_lo_q <= cfg_data;
					silsu_pkg::CFG_WIN_HIGH: win_hi_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign stat.func     = op_q.func;
	assign stat.fault    = fault_c;
	assign stat.clr_last = (clr_addr_q == LAST_ADDR);

	assign result.effective_address = $signed(ea_q);
	assign result.accumulator_value = acc_q;
	assign result.address_fault     = fault_q;

endmodule

@@ hdl/silsu_ctrl.sv @@
// ----------------------------------------------------------------------------
// Scaled-index load/store unit controller
// Sequences the memory clear, the address stages, the window check and the
// byte-at-a-time memory access, and issues the result strobe.
// ----------------------------------------------------------------------------
module silsu_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output silsu_pkg::dp_cmd_t  cmd,
	input  silsu_pkg::dp_stat_t stat
);

	silsu_pkg::state_t state_q;
	silsu_pkg::state_t state_d;
	logic [1:0]        cnt_q;
	logic [1:0]        cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= silsu_pkg::S_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		case (state_q)
			silsu_pkg::S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = silsu_pkg::S_IDLE;
				end
			end
			silsu_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = silsu_pkg::S_MUL;
				end
			end
			silsu_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = silsu_pkg::S_ADD;
			end
			silsu_pkg::S_ADD: begin
				cmd.add = 1'b1;
				state_d = silsu_pkg::S_CHK;
			end
			silsu_pkg::S_CHK: begin
				cmd.chk = 1'b1;
				cnt_d   = '0;
				case (stat.func)
					silsu_pkg::FUNC_LEA: begin
						cmd.reg_wr = 1'b1;
						state_d    = silsu_pkg::S_RESP;
					end
					silsu_pkg::FUNC_STORE: begin
						state_d = stat.fault ? silsu_pkg::S_RESP : silsu_pkg::S_STORE;
					end
					silsu_pkg::FUNC_LOAD: begin
						state_d = stat.fault ? silsu_pkg::S_RESP : silsu_pkg::S_LOAD;
					end
					default: begin
						state_d = silsu_pkg::S_RESP;
					end
				endcase
			end
			silsu_pkg::S_STORE: begin
				cmd.mem_wr   = 1'b1;
				cmd.byte_sel = cnt_q;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == silsu_pkg::LAST_BYTE) begin
					state_d = silsu_pkg::S_RESP;
				end
			end
			silsu_pkg::S_LOAD: begin
				cmd.mem_rd   = 1'b1;
				cmd.byte_sel = cnt_q;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == silsu_pkg::LAST_BYTE) begin
					state_d = silsu_pkg::S_WAIT;
				end
			end
			silsu_pkg::S_WAIT: begin
				// The last byte lands in the accumulator at the end of this cycle.
				state_d = silsu_pkg::S_RESP;
			end
			silsu_pkg::S_RESP: begin
				done    = 1'b1;
				state_d = silsu_pkg::S_IDLE;
			end
			default: begin
				state_d = silsu_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ test/scaled_index_load_store_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scaled-index load/store unit testbench
// Walks a short table of directed operations and window settings, then runs
// targeted random operations under several window settings. Every result
// beat is checked against a hand-written result or a behavioral model of
// the registers, the accumulator and the byte memory.
// ----------------------------------------------------------------------------
module scaled_index_load_store_unit_test;

	// Operation code and register indexes that the block must accept and ignore.
	localparam logic [1:0] FUNC_SPARE  = 2'd3;
	localparam logic [1:0] CFG_SPARE_A = 2'd2;
	localparam logic [1:0] CFG_SPARE_B = 2'd3;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_OPS     = 220;

	typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

	// One line of the directed table. Either a register write or an operation;
	// an operation row may carry a hand-written expected result.
	typedef struct packed {
		row_kind_t          kind;
		logic [1:0]         cfg_index;
		logic [11:0]        cfg_data;
		silsu_pkg::op_t     op;
		logic               typed;
		silsu_pkg::result_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	silsu_pkg::op_t     op;
	logic               busy;
	logic               done;
	silsu_pkg::result_t result;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [1:0]         cfg_index;
	logic [11:0]        cfg_data;

	// Model state: what the block should hold after every accepted operation.
	logic [31:0] reg_file [silsu_pkg::NUM_REGS_DEF];
	logic [31:0] acc;
	logic [7:0]  mem_bytes [silsu_pkg::MEM_BYTES_DEF];
	logic [11:0] win_low;
	logic [11:0] win_high;

	// Results that have been predicted but whose beat has not come back yet.
	silsu_pkg::result_t pending[$];
	stim_row_t          directed[$];
	int                 errors;
	bit                 idle_on;

	scaled_index_load_store_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop, far beyond the slowest correct run: the memory sweep after
	// reset plus about 1350 operations, each at the longest operation time and
	// the longest random gap.
	initial begin
		#2000000;
		$display("scaled_index_load_store_unit_test: FAIL");
		$finish;
	end

	// Executes one operation on the model state and returns its result.
	// The address is computed in 32-bit wrapping arithmetic. A memory access
	// faults when the address is negative, at or below the low window bound,
	// above the high bound, or when the word would run past the end of memory.
	// A faulted access leaves memory and accumulator alone.
	function automatic silsu_pkg::result_t apply_op(silsu_pkg::op_t o);
		logic [31:0]        ea;
		logic               fault;
		silsu_pkg::result_t r;
		ea = o.displacement + reg_file[o.base_reg] + reg_file[o.index_reg] * {24'd0, o.scale};
		fault = 1'b0;
		case (o.func)
			silsu_pkg::FUNC_LEA: begin
				reg_file[o.dest_reg] = ea;
			end
			silsu_pkg::FUNC_STORE, silsu_pkg::FUNC_LOAD: begin
				if (ea[31] || ea <= {20'd0, win_low} || ea > {20'd0, win_high}
						|| ea > 32'(silsu_pkg::MEM_BYTES_DEF - 4)) begin
					fault = 1'b1;
				end else if (o.func == silsu_pkg::FUNC_STORE) begin
					// Most significant byte goes to the lowest address.
					mem_bytes[ea]     = acc[31:24];
					mem_bytes[ea + 1] = acc[23:16];
					mem_bytes[ea + 2] = acc[15:8];
					mem_bytes[ea + 3] = acc[7:0];
				end else begin
					acc = {mem_bytes[ea], mem_bytes[ea + 1], mem_bytes[ea + 2], mem_bytes[ea + 3]};
				end
			end
			default: begin
				// The unused code only reports the address.
			end
		endcase
		r.effective_address = ea;
		r.accumulator_value = acc;
		r.address_fault     = fault;
		return r;
	endfunction

	function automatic stim_row_t op_row(logic [1:0] f, logic [3:0] d, logic [31:0] disp,
			logic [3:0] b, logic [3:0] i, logic [7:0] s, bit lit = 1'b0,
			logic [31:0] ea = '0, logic [31:0] a = '0, logic flt = 1'b0);
		stim_row_t row;
		row = '0;
		row.kind                   = ROW_OP;
		row.op.func                = f;
		row.op.dest_reg            = d;
		row.op.displacement        = disp;
		row.op.base_reg            = b;
		row.op.index_reg           = i;
		row.op.scale               = s;
		row.typed                  = lit;
		row.want.effective_address = ea;
		row.want.accumulator_value = a;
		row.want.address_fault     = flt;
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [1:0] idx, logic [11:0] val);
		stim_row_t row;
		row = '0;
		row.kind      = ROW_CFG;
		row.cfg_index = idx;
		row.cfg_data  = val;
		return row;
	endfunction

	// Addresses that matter: a small shared region so that loads find earlier
	// stores (words overlap at any byte offset), both window edges, the end of
	// memory and beyond, negative addresses, and anything in memory.
	function automatic logic [31:0] pick_address();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 32'd2040 + $urandom_range(0, 47);
			4:          return {20'd0, win_low} + $urandom_range(0, 3) - 1;
			5:          return {20'd0, win_high} + $urandom_range(0, 3) - 1;
			6:          return 32'd4088 + $urandom_range(0, 11);
			7:          return {1'b1, 31'($urandom)};
			default:    return $urandom_range(0, silsu_pkg::MEM_BYTES_DEF - 1);
		endcase
	endfunction

	// Random operation. Most memory accesses and half of the address loads have
	// their displacement solved against the current register contents, so the
	// address lands where it is interesting whatever the registers hold. The
	// rest keep fully random fields.
	function automatic silsu_pkg::op_t make_op();
		silsu_pkg::op_t o;
		logic [31:0]    target;
		int             pick;
		o.func         = 2'($urandom);
		o.dest_reg     = 4'($urandom);
		o.displacement = $urandom;
		o.base_reg     = 4'($urandom);
		o.index_reg    = 4'($urandom);
		o.scale        = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			o.func = $urandom_range(0, 1) ? silsu_pkg::FUNC_STORE : silsu_pkg::FUNC_LOAD;
		end else if (pick < 75) begin
			o.func = silsu_pkg::FUNC_LEA;
		end else if (pick < 82) begin
			o.func = FUNC_SPARE;
		end
		if (pick < 65) begin
			target = pick_address();
			o.displacement = target - reg_file[o.base_reg]
				- reg_file[o.index_reg] * {24'd0, o.scale};
		end
		return o;
	endfunction

	// Presents one operation and holds it until the block takes it. start is
	// left high afterwards so that back-to-back operations need no dead cycle;
	// a random gap lowers it for a burst of cycles.
	task automatic send(input silsu_pkg::op_t o, input bit typed,
			input silsu_pkg::result_t want);
		silsu_pkg::result_t r;
		start <= 1'b1;
		op    <= o;
		do @(posedge clk); while (busy);
		r = apply_op(o);
		pending.push_back(typed ? want : r);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// One register write beat, then a wait with valid low so valid never drops
	// and rises within the same step.
	task automatic write_cfg(input logic [1:0] idx, input logic [11:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			silsu_pkg::CFG_WIN_LOW:  win_low  = val;
			silsu_pkg::CFG_WIN_HIGH: win_high = val;
			default:                 ;
		endcase
		@(posedge clk);
	endtask

	// Every operation yields exactly one beat, so once nothing is pending the
	// block is idle and the window may be changed.
	task automatic settle;
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	// Result checker. Beats are sampled on the edge that ends the done cycle;
	// the block updates its outputs after that edge, so the values read here
	// are the ones it presented during the cycle.
	always @(posedge clk) begin
		silsu_pkg::result_t want;
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got ea %h acc %h fault %b",
					$time, result.effective_address, result.accumulator_value,
					result.address_fault);
				errors++;
			end else begin
				want = pending.pop_front();
				if (result.effective_address !== want.effective_address) begin
					$display("%0t: effective_address expected %h, got %h", $time,
						want.effective_address, result.effective_address);
					errors++;
				end
				if (result.accumulator_value !== want.accumulator_value) begin
					$display("%0t: accumulator_value expected %h, got %h", $time,
						want.accumulator_value, result.accumulator_value);
					errors++;
				end
				if (result.address_fault !== want.address_fault) begin
					$display("%0t: address_fault expected %b, got %b", $time,
						want.address_fault, result.address_fault);
					errors++;
				end
			end
		end
	end

	initial begin
		logic [11:0] lo;
		logic [11:0] hi;

		arst_n    = 1'b0;
		start     = 1'b0;
		op        = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		errors    = 0;
		idle_on   = 1'b1;
		foreach (reg_file[k]) reg_file[k] = '0;
		foreach (mem_bytes[k]) mem_bytes[k] = '0;
		acc      = silsu_pkg::ACC_RESET;
		win_low  = silsu_pkg::WIN_LOW_RESET;
		win_high = silsu_pkg::WIN_HIGH_RESET;

		// Directed table. Results are spelled out where they follow from reset
		// state and the window bounds alone; the other rows use the model.
		// Load effective address of both 32-bit extremes, accumulator at reset.
		directed.push_back(op_row(silsu_pkg::FUNC_LEA, 1, 32'h7FFF_FFFF, 0, 0, 0,
			1, 32'h7FFF_FFFF, silsu_pkg::ACC_RESET, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LEA, 2, 32'h8000_0000, 0, 0, 0,
			1, 32'h8000_0000, silsu_pkg::ACC_RESET, 0));
		// Store the reset accumulator, read it back misaligned, then aligned.
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 2000, 0, 0, 0,
			1, 2000, silsu_pkg::ACC_RESET, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 2001, 0, 0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 2000, 0, 0, 0,
			1, 2000, silsu_pkg::ACC_RESET, 0));
		// A negative address faults, as does the exclusive low bound itself.
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 0, 2, 0, 0,
			1, 32'h8000_0000, silsu_pkg::ACC_RESET, 1));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 1024, 0, 0, 0,
			1, 1024, silsu_pkg::ACC_RESET, 1));
		// Memory that was never stored to reads as zero after the sweep.
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 1025, 0, 0, 0, 1, 1025, 32'h0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 2000, 0, 0, 0,
			1, 2000, silsu_pkg::ACC_RESET, 0));
		// The high bound is inclusive; one byte past it faults.
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 4092, 0, 0, 0,
			1, 4092, silsu_pkg::ACC_RESET, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 4093, 0, 0, 0,
			1, 4093, silsu_pkg::ACC_RESET, 1));
		// The unused code reports the address and changes nothing.
		directed.push_back(op_row(FUNC_SPARE, 15, 32'h1234_5678, 0, 0, 8'hFF,
			1, 32'h1234_5678, silsu_pkg::ACC_RESET, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LEA, 3, 5, 0, 0, 0,
			1, 5, silsu_pkg::ACC_RESET, 0));
		// Full scale on a register index, then accesses through the result.
		directed.push_back(op_row(silsu_pkg::FUNC_LEA, 4, 32'hFFFF_FFFF, 3, 3, 8'hFF));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 0, 4, 0, 0));
		// Address arithmetic that wraps, and a wrap that lands inside memory.
		directed.push_back(op_row(silsu_pkg::FUNC_LEA, 5, 32'h7FFF_FFFF, 1, 1, 8'hFF));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 32'h8000_0800, 2, 0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 1, 4, 3, 8'hFF));
		directed.push_back(op_row(silsu_pkg::FUNC_LEA, 15, 0, 15, 15, 8'hFF));
		// Widest window: the end of memory now decides, and address zero is at
		// the low bound. Writes to the spare indexes must be ignored.
		directed.push_back(cfg_row(silsu_pkg::CFG_WIN_LOW, 12'h000));
		directed.push_back(cfg_row(silsu_pkg::CFG_WIN_HIGH, 12'hFFF));
		directed.push_back(cfg_row(CFG_SPARE_A, 12'hFFF));
		directed.push_back(cfg_row(CFG_SPARE_B, 12'h000));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 4093, 0, 0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 4092, 0, 0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 0, 0, 0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_STORE, 0, 1, 0, 0, 0));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 4096, 0, 0, 0));
		// Inverted window: every access faults.
		directed.push_back(cfg_row(silsu_pkg::CFG_WIN_LOW, 12'hFFF));
		directed.push_back(cfg_row(silsu_pkg::CFG_WIN_HIGH, 12'h000));
		directed.push_back(op_row(silsu_pkg::FUNC_LOAD, 0, 2000, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The window may be written during the memory sweep; operations simply
		// wait on busy until it ends.
		write_cfg(silsu_pkg::CFG_WIN_LOW, silsu_pkg::WIN_LOW_RESET);
		write_cfg(silsu_pkg::CFG_WIN_HIGH, silsu_pkg::WIN_HIGH_RESET);

		foreach (directed[n]) begin
			if (directed[n].kind == ROW_CFG) begin
				settle();
				write_cfg(directed[n].cfg_index, directed[n].cfg_data);
			end else begin
				send(directed[n].op, directed[n].typed, directed[n].want);
			end
		end

		// Random phases, each under its own window. The last phase runs with
		// no idling at all so operations follow back to back.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle();
			case (ph)
				0: begin
					lo = silsu_pkg::WIN_LOW_RESET;
					hi = silsu_pkg::WIN_HIGH_RESET;
				end
				1: begin
					lo = 12'h000;
					hi = 12'hFFF;
				end
				2: begin
					lo = 12'hFFF;
					hi = 12'h000;
				end
				4: begin
					lo = 12'($urandom);
					hi = 12'($urandom);
				end
				default: begin
					lo = 12'($urandom_range(0, 2039));
					hi = 12'($urandom_range(2088, 4095));
				end
			endcase
			write_cfg(silsu_pkg::CFG_WIN_LOW, lo);
			write_cfg(silsu_pkg::CFG_WIN_HIGH, hi);
			if ($urandom_range(0, 1)) begin
				write_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 12'($urandom));
			end
			for (int n = 0; n < PHASE_OPS; n++) begin
				if (n % 40 == 0) begin
					idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 1) == 1);
				end
				send(make_op(), 1'b0, '0);
			end
		end

		// Drain, then keep watching for any stray beat before the verdict.
		settle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("scaled_index_load_store_unit_test: PASS");
		end else begin
			$display("scaled_index_load_store_unit_test: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/silsu_pkg.sv
hdl/silsu_dp.sv
hdl/silsu_ctrl.sv
hdl/scaled_index_load_store_unit.sv
test/scaled_index_load_store_unit_test.sv
